>>> sv/sorted_list_table_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Sorted list table engine: assertion macros
// Concurrent checks used by the assertions of the engine unit.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_ENGINE_UNIT_MACROS_SVH
`define SORTED_LIST_TABLE_ENGINE_UNIT_MACROS_SVH

// Condition in one cycle implies a condition in the next.
`define SLTE_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Condition implies a condition in the same cycle.
`define SLTE_ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

`endif

>>> sv/slte_pkg.sv
// ----------------------------------------------------------------------------
// slte_pkg
// Widths, operation and status codes and cell control for the sorted list
// table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slte_pkg;

  localparam int DATA_W     = 32;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int READ_LIMIT = 32;

  localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_ASC  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_DESC = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    CMD_HOLD = 3'd0,
    CMD_CMP  = 3'd1,
    CMD_INS  = 3'd2,
    CMD_DEL  = 3'd3,
    CMD_ROTL = 3'd4,
    CMD_ROTR = 3'd5
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                 cmd;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/slte_req_if.sv
// ----------------------------------------------------------------------------
// slte_req_if
// Request channel: operation mode and operand value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface slte_req_if
  import slte_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);

endinterface

`default_nettype wire

>>> sv/slte_rsp_if.sv
// ----------------------------------------------------------------------------
// slte_rsp_if
// Response channel: entry or echoed value, status and last marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface slte_rsp_if
  import slte_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] item_value;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  modport source (output valid, item_value, status, last, input ready);
  modport sink   (input valid, item_value, status, last, output ready);

endinterface

`default_nettype wire

>>> sv/slte_cell.sv
// ----------------------------------------------------------------------------
// slte_cell
// One entry of the sorted row: compares, shifts for insert and delete, and
// rotates around the ring for read-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slte_cell
  import slte_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic                     occ,
  input  wire logic signed [DATA_W-1:0] left_data,
  input  wire logic                     left_lt,
  input  wire logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0]      data,
  output logic                          lt,
  output logic                          eq
);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_CMP: begin
        lt <= occ && (data < ctrl.value);
        eq <= occ && (data == ctrl.value);
      end
      CMD_INS: begin
        if (!lt) begin
          data <= left_lt ? ctrl.value : left_data;
        end
      end
      CMD_DEL: begin
        if (!lt) begin
          data <= right_data;
        end
      end
      CMD_ROTL: begin
        data <= right_data;
      end
      CMD_ROTR: begin
        data <= left_data;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/sorted_list_table_engine_unit.sv
// Insert, search and delete: the compare over the cell row runs in the cycle
// of acceptance, then an update step in S_EXEC loads the result into the
// output register once the output slot is free.
// Read-out: a full rotation of the cell ring; one entry leaves per cycle while
// the output side takes it.
// Reset (synchronous, active high) clears the entry count, the state machine
// and the output valid; the entries themselves are not cleared.
// ----------------------------------------------------------------------------
// sorted_list_table_engine_unit
// Sorted list of signed values held in a ring of compare-and-shift cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_list_table_engine_unit_macros.svh"

module sorted_list_table_engine_unit
  import slte_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  slte_req_if.sink    req,
  slte_rsp_if.source  rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = $clog2(CAPACITY);
  localparam int LW = $clog2(READ_LIMIT + 1);
  localparam int XW = ((CW > LW) ? CW : LW) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } fsm_t;

  fsm_t                     state;
  fsm_t                     state_next;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [RW-1:0]            rot_cnt;
  logic [RW-1:0]            rot_cnt_next;
  logic [MODE_W-1:0]        op_mode;
  logic signed [DATA_W-1:0] op_value;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_item_value;
  logic [STATUS_W-1:0]      out_status;
  logic                     out_last;

  logic                     load;
  logic signed [DATA_W-1:0] load_value;
  logic [STATUS_W-1:0]      load_status;
  logic                     load_last;

  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_lt;
  logic [CAPACITY-1:0]      cell_eq;

  logic                     slot_free;
  logic                     accept;
  logic                     found;
  logic                     full;
  logic                     asc;
  logic [XW-1:0]            cnt_x;
  logic [XW-1:0]            n_x;
  logic [XW-1:0]            rot_x;
  logic [XW-1:0]            skip_x;
  logic [XW-1:0]            eidx_x;
  logic                     emit;

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign found     = |cell_eq;
  assign full      = (count == CW'(CAPACITY));
  assign asc       = (op_mode == MODE_READ_ASC);

  assign cnt_x  = XW'(count);
  assign n_x    = (cnt_x > XW'(READ_LIMIT)) ? XW'(READ_LIMIT) : cnt_x;
  assign rot_x  = XW'(rot_cnt);
  assign skip_x = XW'(CAPACITY) - cnt_x;
  assign eidx_x = asc ? rot_x : (rot_x - skip_x);
  assign emit   = (asc || (rot_x >= skip_x)) && (eidx_x < n_x);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      localparam int L = (gi + CAPACITY - 1) % CAPACITY;
      localparam int R = (gi + 1) % CAPACITY;
      slte_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (count > CW'(gi)),
        .left_data  (cell_data[L]),
        .left_lt    ((gi == 0) ? 1'b1 : cell_lt[L]),
        .right_data (cell_data[R]),
        .data       (cell_data[gi]),
        .lt         (cell_lt[gi]),
        .eq         (cell_eq[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next   = state;
    count_next   = count;
    rot_cnt_next = rot_cnt;
    load         = 1'b0;
    load_value   = op_value;
    load_status  = STATUS_OK;
    load_last    = 1'b1;
    ctrl.cmd     = CMD_HOLD;
    ctrl.value   = op_value;
    case (state)
      S_IDLE: begin
        ctrl.cmd   = CMD_CMP;
        ctrl.value = req.value;
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
          case (op_mode)
            MODE_INSERT: begin
              if (full) begin
                load_status = STATUS_FULL;
              end else begin
                ctrl.cmd   = CMD_INS;
                count_next = count + CW'(1);
              end
            end
            MODE_SEARCH: begin
              load_status = found ? STATUS_OK : STATUS_NOT_FOUND;
            end
            MODE_DELETE: begin
              if (count == '0) begin
                load_status = STATUS_EMPTY;
              end else if (!found) begin
                load_status = STATUS_NOT_FOUND;
              end else begin
                ctrl.cmd   = CMD_DEL;
                count_next = count - CW'(1);
              end
            end
            MODE_READ_ASC, MODE_READ_DESC: begin
              if (count == '0) begin
                load_value  = '0;
                load_status = STATUS_EMPTY;
              end else begin
                load         = 1'b0;
                rot_cnt_next = '0;
                state_next   = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        load_value = asc ? cell_data[0] : cell_data[CAPACITY-1];
        load_last  = (eidx_x == n_x - XW'(1));
        if (!emit || slot_free) begin
          load     = emit;
          ctrl.cmd = asc ? CMD_ROTL : CMD_ROTR;
          if (rot_cnt == RW'(CAPACITY - 1)) begin
            state_next = S_IDLE;
          end else begin
            rot_cnt_next = rot_cnt + RW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rot_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rot_cnt <= rot_cnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= req.mode;
      op_value <= req.value;
    end
    if (load) begin
      out_item_value <= load_value;
      out_status     <= load_status;
      out_last       <= load_last;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.item_value = out_item_value;
  assign rsp.status     = out_status;
  assign rsp.last       = out_last;

  `SLTE_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == S_EXEC,
                    "accepted transaction did not reach the update cycle")
  `SLTE_ASSERT_NEXT(a_insert_count, clk, rst,
                    state == S_EXEC && slot_free && op_mode == MODE_INSERT && !full,
                    count == $past(count) + CW'(1),
                    "insert did not advance the entry count")
  `SLTE_ASSERT_SAME(a_read_nonempty, clk, rst, state == S_READ,
                    count != '0 && !req.ready,
                    "read-out running on an empty list or with the request side open")

endmodule

`default_nettype wire

>>> sim/sorted_list_table_engine_unit_test.sv
// ----------------------------------------------------------------------------
// sorted_list_table_engine_unit_test
// Drives insert, search, delete, read-out and spare-mode requests into the
// sorted list table engine. Results are predicted from a software copy of the
// table and compared field by field in arrival order. Both channels idle and
// stall at random, and the random part fills the table to capacity and drains
// it again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_table_engine_unit_test;
  import slte_pkg::*;

  localparam int TABLE_DEPTH  = 32;
  localparam int RANDOM_ITEMS = 200;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;

  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    logic signed [DATA_W-1:0] item_value;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } table_result_t;

  class sorted_table_scoreboard;
    logic signed [DATA_W-1:0] entries [TABLE_DEPTH];
    int                       count;
    table_result_t            awaited [$];
    int                       errors;
    int                       checked;
    int                       full_drops;
    int                       empty_reads;

    function new();
      count       = 0;
      errors      = 0;
      checked     = 0;
      full_drops  = 0;
      empty_reads = 0;
    endfunction

    function void await_result(logic signed [DATA_W-1:0] v, logic [STATUS_W-1:0] s,
                               logic l);
      table_result_t r;
      r.item_value = v;
      r.status     = s;
      r.last       = l;
      awaited.push_back(r);
    endfunction

    function int find_entry(logic signed [DATA_W-1:0] v);
      for (int i = 0; i < count; i++) begin
        if (entries[i] == v) return i;
      end
      return -1;
    endfunction

    function void note_request(logic [MODE_W-1:0] m, logic signed [DATA_W-1:0] v);
      int pos;
      int n;
      int idx;
      pos = 0;
      case (m)
        MODE_INSERT: begin
          if (count >= TABLE_DEPTH) begin
            full_drops++;
            await_result(v, STATUS_FULL, 1'b1);
          end else begin
            while (pos < count && entries[pos] < v) pos++;
            for (int i = count; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = v;
            count++;
            await_result(v, STATUS_OK, 1'b1);
          end
        end
        MODE_SEARCH: begin
          await_result(v, (find_entry(v) >= 0) ? STATUS_OK : STATUS_NOT_FOUND, 1'b1);
        end
        MODE_DELETE: begin
          pos = find_entry(v);
          if (count == 0) begin
            await_result(v, STATUS_EMPTY, 1'b1);
          end else if (pos < 0) begin
            await_result(v, STATUS_NOT_FOUND, 1'b1);
          end else begin
            for (int i = pos; i + 1 < count; i++) entries[i] = entries[i+1];
            count--;
            await_result(v, STATUS_OK, 1'b1);
          end
        end
        MODE_READ_ASC, MODE_READ_DESC: begin
          if (count == 0) begin
            empty_reads++;
            await_result('0, STATUS_EMPTY, 1'b1);
          end else begin
            n = (count < READ_LIMIT) ? count : READ_LIMIT;
            for (int i = 0; i < n; i++) begin
              idx = (m == MODE_READ_ASC) ? i : count - 1 - i;
              await_result(entries[idx], STATUS_OK, i == n - 1);
            end
          end
        end
        default: begin
          await_result(v, STATUS_OK, 1'b1);
        end
      endcase
    endfunction

    function void check_result(logic signed [DATA_W-1:0] v, logic [STATUS_W-1:0] s,
                               logic l);
      table_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: item_value %0d status %0d last %0b",
                 $time, v, s, l);
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (v !== e.item_value) begin
        errors++;
        $display("%0t: item_value mismatch: expected %0d actual %0d",
                 $time, e.item_value, v);
      end
      if (s !== e.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, s);
      end
      if (l !== e.last) begin
        errors++;
        $display("%0t: last mismatch: expected %0b actual %0b", $time, e.last, l);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   idle_pct;
  int   sent_items;

  sorted_table_scoreboard table_sb;

  slte_req_if req ();
  slte_rsp_if rsp ();

  sorted_list_table_engine_unit #(
    .CAPACITY(TABLE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_request(input logic [MODE_W-1:0] m,
                              input logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode  <= m;
    req.value <= v;
    do @(posedge clk); while (req.ready !== 1'b1);
    table_sb.note_request(m, v);
    sent_items++;
  endtask

  task automatic wait_results_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (table_sb.awaited.size() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int                       r;
    logic signed [DATA_W-1:0] v;
    r = $urandom_range(99);
    if (r < 40) begin
      v = $urandom_range(20);
      return v - 10;
    end
    if (r < 60 && table_sb.count > 0) return table_sb.entries[$urandom_range(table_sb.count - 1)];
    if (r < 70) begin
      case ($urandom_range(3))
        0:       return VALUE_MIN;
        1:       return VALUE_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input int insert_pct, input int delete_pct);
    int r;
    r = $urandom_range(99);
    if (r < insert_pct) return MODE_INSERT;
    if (r < insert_pct + delete_pct) return MODE_DELETE;
    if (r < insert_pct + delete_pct + 10) return MODE_SEARCH;
    if (r < insert_pct + delete_pct + 17) begin
      return $urandom_range(1) ? MODE_READ_ASC : MODE_READ_DESC;
    end
    return MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
  endfunction

  task automatic send_random(input int insert_pct, input int delete_pct);
    logic [MODE_W-1:0]        m;
    logic signed [DATA_W-1:0] v;
    m = pick_mode(insert_pct, delete_pct);
    v = pick_value();
    if (m == MODE_DELETE && table_sb.count > 0 && $urandom_range(99) < 80) begin
      v = table_sb.entries[$urandom_range(table_sb.count - 1)];
    end
    send_request(m, v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        table_sb.check_result(rsp.item_value, rsp.status, rsp.last);
      end
      rsp.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    int round;
    int directed_items;
    table_sb   = new();
    idle_pct   = 23;
    sent_items = 0;
    round      = 0;
    rst        = 1'b1;
    req.valid  = 1'b0;
    req.mode   = MODE_INSERT;
    req.value  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_request(MODE_READ_ASC, 32'sd9);
    send_request(MODE_READ_DESC, -32'sd9);
    send_request(MODE_SEARCH, 32'sd5);
    send_request(MODE_DELETE, 32'sd5);
    send_request(MODE_INSERT, VALUE_MAX);
    send_request(MODE_INSERT, VALUE_MIN);
    send_request(MODE_INSERT, 32'sd0);
    send_request(MODE_INSERT, -32'sd1);
    send_request(MODE_INSERT, 32'sd5);
    send_request(MODE_INSERT, 32'sd5);
    send_request(MODE_SEARCH, 32'sd5);
    send_request(MODE_SEARCH, 32'sd6);
    send_request(MODE_SEARCH, VALUE_MIN);
    send_request(MODE_READ_ASC, '0);
    send_request(MODE_READ_DESC, '1);
    send_request(MODE_DELETE, 32'sd6);
    send_request(MODE_DELETE, 32'sd5);
    send_request(MODE_DELETE, VALUE_MIN);
    send_request(MODE_DELETE, VALUE_MAX);
    send_request(MODE_SEARCH, VALUE_MAX);
    for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++) begin
      send_request(MODE_W'(m), pick_value());
    end
    send_request(MODE_READ_ASC, VALUE_MAX);
    directed_items = sent_items;

    wait_results_drained();
    while (sent_items < directed_items + RANDOM_ITEMS) begin
      idle_pct = (round == 1) ? 0 : 23;
      while (table_sb.count < TABLE_DEPTH) send_random(70, 5);
      send_request(MODE_INSERT, pick_value());
      send_request(MODE_INSERT, pick_value());
      send_request(MODE_READ_ASC, pick_value());
      send_request(MODE_READ_DESC, pick_value());
      while (table_sb.count > 0) send_random(5, 70);
      send_request(MODE_DELETE, pick_value());
      send_request(MODE_READ_DESC, pick_value());
      wait_results_drained();
      repeat (12) send_random(40, 30);
      round++;
    end

    idle_pct = 23;
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests in %0d fill and drain rounds, %0d results checked.",
             sent_items, round, table_sb.checked);
    $display("Inserts refused on a full table: %0d, read-outs of an empty table: %0d.",
             table_sb.full_drops, table_sb.empty_reads);
    if (table_sb.errors == 0) begin
      $display("sorted_list_table_engine_unit_test: done, clean");
    end else begin
      $display("sorted_list_table_engine_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d results outstanding.", table_sb.awaited.size());
    $display("sorted_list_table_engine_unit_test: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/slte_pkg.sv
sv/slte_req_if.sv
sv/slte_rsp_if.sv
sv/slte_cell.sv
sv/sorted_list_table_engine_unit.sv
sim/sorted_list_table_engine_unit_test.sv
